// File: hw/rtl/tcrc_pkg.sv
// Package with the types, codes and sizes shared by the tape channel read controller.
package tcrc_pkg;

  localparam int unsigned BUFFER_WORDS     = 4096;
  localparam int unsigned MAX_RECORD_BYTES = 6144;

  localparam int unsigned PTR_W    = $clog2(BUFFER_WORDS);
  localparam int unsigned CNT_W    = PTR_W + 1;
  localparam int unsigned BUF_ROWS = BUFFER_WORDS / 2;
  localparam int unsigned ROW_AW   = $clog2(BUF_ROWS);

  localparam logic [1:0] OP_FUNC       = 2'd0;
  localparam logic [1:0] OP_CHAN_REQ   = 2'd1;
  localparam logic [1:0] OP_MEDIUM     = 2'd2;
  localparam logic [1:0] OP_MEDIUM_END = 2'd3;

  localparam logic [11:0] FN_MASK          = 12'o7770;
  localparam logic [11:0] FN_SELECT        = 12'o2000;
  localparam logic [11:0] FN_WRITE_BIN     = 12'o2010;
  localparam logic [11:0] FN_READ_BIN      = 12'o2020;
  localparam logic [11:0] FN_BACKSPACE     = 12'o2030;
  localparam logic [11:0] FN_REWIND        = 12'o2060;
  localparam logic [11:0] FN_REWIND_UNLOAD = 12'o2070;
  localparam logic [11:0] FN_STATUS        = 12'o2100;
  localparam logic [11:0] FN_WRITE_BCD     = 12'o2210;
  localparam logic [11:0] FN_READ_BCD      = 12'o2220;
  localparam logic [11:0] FN_FILE_MARK     = 12'o2610;

  localparam logic [5:0] ST_READY     = 6'o00;
  localparam logic [5:0] ST_NOT_READY = 6'o01;
  localparam logic [5:0] ST_EOT       = 6'o10;

  localparam logic [2:0] ER_NONE        = 3'd0;
  localparam logic [2:0] ER_UNSUPPORTED = 3'd1;
  localparam logic [2:0] ER_SELECT      = 3'd2;
  localparam logic [2:0] ER_TOO_LONG    = 3'd3;
  localparam logic [2:0] ER_SHORT       = 3'd4;
  localparam logic [2:0] ER_TRAILER     = 3'd5;

  localparam logic [1:0] MREQ_NONE   = 2'd0;
  localparam logic [1:0] MREQ_RECORD = 2'd1;
  localparam logic [1:0] MREQ_REWIND = 2'd2;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HEADER,
    PH_DATA,
    PH_TRAILER
  } phase_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [11:0] func_code;
    logic [7:0]  medium_byte;
    logic        channel_full;
  } in_req_t;

  typedef struct packed {
    logic        func_accepted;
    logic        data_valid;
    logic [11:0] data_word;
    logic        channel_stop;
    logic [1:0]  medium_request;
    logic [2:0]  request_unit;
    logic [2:0]  error_code;
    logic [5:0]  status_word;
  } result_t;

  typedef struct packed {
    logic              en;
    logic [ROW_AW-1:0] row;
    logic [23:0]       data;
  } store_wr_t;

  typedef struct packed {
    logic             en;
    logic [PTR_W-1:0] addr;
  } store_rd_t;

endpackage

// File: hw/rtl/tcrc_store.sv
// Record word buffer: one row of two words written per cycle, one word read per cycle.
module tcrc_store (
  input  logic                clk_i,
  input  tcrc_pkg::store_wr_t wr_i,
  input  tcrc_pkg::store_rd_t rd_i,
  output logic [11:0]         rdata_o
);

  logic [23:0] mem [tcrc_pkg::BUF_ROWS];
  logic [23:0] rdata_q;
  logic        half_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.row] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rdata_q <= mem[rd_i.addr[tcrc_pkg::PTR_W-1:1]];
      half_q  <= rd_i.addr[0];
    end
  end

  // The even word of a row sits in the upper half.
  assign rdata_o = half_q ? rdata_q[11:0] : rdata_q[23:12];

endmodule

// File: hw/rtl/tape_channel_read_controller_core.sv
// Top level of the tape channel read controller: request decode, record parser and buffer.
// Each request is captured in an input register, handled by the decode and parse logic,
// and placed in a result register, so one request is taken every clock cycle while the
// output is not stalled; the word buffer is a single-port-read memory of paired words,
// and a buffered data word is read from it in the same cycle that its request moves to
// the result register.
module tape_channel_read_controller_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  tcrc_pkg::in_req_t in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output tcrc_pkg::result_t out_res_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [7:0]        cfg_data_i
);

  localparam int unsigned PTR_W = tcrc_pkg::PTR_W;
  localparam int unsigned CNT_W = tcrc_pkg::CNT_W;

  logic                  s1_q, o_q, mem_sel_q;
  tcrc_pkg::in_req_t     in_q;
  tcrc_pkg::result_t     res_q, res_d;
  logic [7:0]            mask_q;

  logic [11:0]           func_q, func_d;
  logic [2:0]            unit_q, unit_d;
  logic [5:0]            status_q, status_d;
  logic [CNT_W-1:0]      words_q, words_d;
  logic [PTR_W-1:0]      rptr_q, rptr_d;
  logic [CNT_W-1:0]      wptr_q, wptr_d;
  tcrc_pkg::phase_e      phase_q, phase_d;
  logic [31:0]           header_q, header_d;
  logic [31:0]           trailer_q, trailer_d;
  logic [12:0]           seen_q, seen_d;
  logic [15:0]           pend_q, pend_d;
  logic [1:0]            bphase_q, bphase_d;

  logic                  out_free, fire, mem_rd;
  tcrc_pkg::store_wr_t   wr;
  tcrc_pkg::store_rd_t   rd;
  logic [11:0]           store_word;

  assign out_free    = !o_q || !out_stall_i;
  assign fire        = s1_q && out_free;
  assign in_stall_o  = s1_q && !out_free;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    logic [11:0] code;
    logic        attached;
    logic [12:0] seen_inc;
    logic        pack;
    logic [7:0]  c1, c2, c3;

    code     = in_q.func_code & tcrc_pkg::FN_MASK;
    attached = mask_q[unit_q];
    seen_inc = seen_q + 13'd1;
    pack     = 1'b0;
    c1       = '0;
    c2       = '0;
    c3       = '0;

    func_d    = func_q;
    unit_d    = unit_q;
    status_d  = status_q;
    words_d   = words_q;
    rptr_d    = rptr_q;
    wptr_d    = wptr_q;
    phase_d   = phase_q;
    header_d  = header_q;
    trailer_d = trailer_q;
    seen_d    = seen_q;
    pend_d    = pend_q;
    bphase_d  = bphase_q;
    mem_rd    = 1'b0;
    res_d     = '0;

    case (in_q.opcode)
      tcrc_pkg::OP_FUNC: begin
        res_d.func_accepted = 1'b1;
        case (code)
          tcrc_pkg::FN_WRITE_BIN, tcrc_pkg::FN_BACKSPACE, tcrc_pkg::FN_REWIND_UNLOAD,
          tcrc_pkg::FN_WRITE_BCD, tcrc_pkg::FN_READ_BCD, tcrc_pkg::FN_FILE_MARK: begin
            func_d           = '0;
            res_d.error_code = tcrc_pkg::ER_UNSUPPORTED;
          end
          tcrc_pkg::FN_REWIND: begin
            func_d = '0;
            if (attached) begin
              res_d.medium_request = tcrc_pkg::MREQ_REWIND;
              res_d.request_unit   = unit_q;
              phase_d              = tcrc_pkg::PH_IDLE;
            end
          end
          tcrc_pkg::FN_STATUS: begin
            func_d = in_q.func_code;
          end
          tcrc_pkg::FN_SELECT: begin
            func_d = '0;
            unit_d = in_q.func_code[2:0];
            if (!mask_q[in_q.func_code[2:0]]) begin
              res_d.error_code = tcrc_pkg::ER_SELECT;
            end
          end
          tcrc_pkg::FN_READ_BIN: begin
            func_d   = in_q.func_code;
            status_d = tcrc_pkg::ST_READY;
            if (words_q == '0) begin
              rptr_d    = '0;
              wptr_d    = '0;
              seen_d    = '0;
              header_d  = '0;
              trailer_d = '0;
              pend_d    = '0;
              bphase_d  = '0;
              if (!attached) begin
                status_d = tcrc_pkg::ST_NOT_READY;
                words_d  = '0;
                phase_d  = tcrc_pkg::PH_IDLE;
              end else begin
                res_d.medium_request = tcrc_pkg::MREQ_RECORD;
                res_d.request_unit   = unit_q;
                phase_d              = tcrc_pkg::PH_HEADER;
              end
            end
          end
          default: begin
            res_d.func_accepted = 1'b0;
          end
        endcase
      end
      tcrc_pkg::OP_CHAN_REQ: begin
        if ((func_q & tcrc_pkg::FN_MASK) == tcrc_pkg::FN_STATUS) begin
          res_d.data_valid = 1'b1;
          res_d.data_word  = {6'd0, status_q};
        end else if ((func_q & tcrc_pkg::FN_MASK) == tcrc_pkg::FN_READ_BIN) begin
          if (!in_q.channel_full) begin
            if (words_q == '0) begin
              res_d.channel_stop = 1'b1;
            end else begin
              words_d          = words_q - 1'b1;
              res_d.data_valid = 1'b1;
              mem_rd           = 1'b1;
              rptr_d           = rptr_q + 1'b1;
            end
          end
        end else begin
          res_d.error_code = tcrc_pkg::ER_UNSUPPORTED;
        end
      end
      tcrc_pkg::OP_MEDIUM: begin
        case (phase_q)
          tcrc_pkg::PH_HEADER: begin
            header_d = header_q | ({24'd0, in_q.medium_byte} << {seen_q[1:0], 3'b000});
            seen_d   = seen_inc;
            if (seen_inc == 13'd4) begin
              seen_d = '0;
              if (header_d == '0) begin
                status_d = tcrc_pkg::ST_READY;
                words_d  = '0;
                phase_d  = tcrc_pkg::PH_IDLE;
              end else if (header_d > 32'(tcrc_pkg::MAX_RECORD_BYTES)) begin
                status_d         = tcrc_pkg::ST_NOT_READY;
                words_d          = '0;
                phase_d          = tcrc_pkg::PH_IDLE;
                res_d.error_code = tcrc_pkg::ER_TOO_LONG;
              end else begin
                phase_d = tcrc_pkg::PH_DATA;
              end
            end
          end
          tcrc_pkg::PH_DATA: begin
            if (bphase_q == 2'd2) begin
              pack     = 1'b1;
              c1       = pend_q[15:8];
              c2       = pend_q[7:0];
              c3       = in_q.medium_byte;
              pend_d   = '0;
              bphase_d = '0;
            end else begin
              pend_d   = {pend_q[7:0], in_q.medium_byte};
              bphase_d = bphase_q + 2'd1;
            end
            seen_d = seen_inc;
            if ({19'd0, seen_inc} >= header_q) begin
              // A trailing partial group is padded with zero bytes.
              if (bphase_d == 2'd1) begin
                pack = 1'b1;
                c1   = pend_d[7:0];
              end else if (bphase_d == 2'd2) begin
                pack = 1'b1;
                c1   = pend_d[15:8];
                c2   = pend_d[7:0];
              end
              pend_d    = '0;
              bphase_d  = '0;
              seen_d    = '0;
              trailer_d = '0;
              phase_d   = tcrc_pkg::PH_TRAILER;
            end
          end
          tcrc_pkg::PH_TRAILER: begin
            trailer_d = trailer_q | ({24'd0, in_q.medium_byte} << {seen_q[1:0], 3'b000});
            seen_d    = seen_inc;
            if (seen_inc == 13'd4) begin
              seen_d  = '0;
              phase_d = tcrc_pkg::PH_IDLE;
              if (trailer_d != header_q) begin
                status_d         = tcrc_pkg::ST_NOT_READY;
                words_d          = '0;
                res_d.error_code = tcrc_pkg::ER_TRAILER;
              end else begin
                words_d  = wptr_q;
                status_d = tcrc_pkg::ST_READY;
              end
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
        case (phase_q)
          tcrc_pkg::PH_HEADER: begin
            status_d = tcrc_pkg::ST_EOT;
            words_d  = '0;
            phase_d  = tcrc_pkg::PH_IDLE;
          end
          tcrc_pkg::PH_DATA: begin
            status_d         = tcrc_pkg::ST_NOT_READY;
            words_d          = '0;
            phase_d          = tcrc_pkg::PH_IDLE;
            res_d.error_code = tcrc_pkg::ER_SHORT;
          end
          tcrc_pkg::PH_TRAILER: begin
            status_d         = tcrc_pkg::ST_NOT_READY;
            words_d          = '0;
            phase_d          = tcrc_pkg::PH_IDLE;
            res_d.error_code = tcrc_pkg::ER_TRAILER;
          end
          default: begin
          end
        endcase
      end
    endcase

    // Words always go in pairs, so the write pointer stays even and one row holds a group.
    wr.en   = fire && pack && !wptr_q[CNT_W-1];
    wr.row  = wptr_q[PTR_W-1:1];
    wr.data = {c1, c2[7:4], c2[3:0], c3};
    if (pack && !wptr_q[CNT_W-1]) begin
      wptr_d = wptr_q + CNT_W'(2);
    end

    res_d.status_word = status_d;
  end

  assign rd.en   = fire && mem_rd;
  assign rd.addr = rptr_q;

  tcrc_store u_store (
    .clk_i   (clk_i),
    .wr_i    (wr),
    .rd_i    (rd),
    .rdata_o (store_word)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q      <= 1'b0;
      o_q       <= 1'b0;
      mask_q    <= 8'd1;
      func_q    <= '0;
      unit_q    <= '0;
      status_q  <= '0;
      words_q   <= '0;
      rptr_q    <= '0;
      wptr_q    <= '0;
      phase_q   <= tcrc_pkg::PH_IDLE;
      header_q  <= '0;
      trailer_q <= '0;
      seen_q    <= '0;
      pend_q    <= '0;
      bphase_q  <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        s1_q <= 1'b1;
      end else if (fire) begin
        s1_q <= 1'b0;
      end
      if (fire) begin
        o_q <= 1'b1;
      end else if (!out_stall_i) begin
        o_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        mask_q <= cfg_data_i;
      end
      if (fire) begin
        func_q    <= func_d;
        unit_q    <= unit_d;
        status_q  <= status_d;
        words_q   <= words_d;
        rptr_q    <= rptr_d;
        wptr_q    <= wptr_d;
        phase_q   <= phase_d;
        header_q  <= header_d;
        trailer_q <= trailer_d;
        seen_q    <= seen_d;
        pend_q    <= pend_d;
        bphase_q  <= bphase_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_req_i;
    end
    if (fire) begin
      res_q     <= res_d;
      mem_sel_q <= mem_rd;
    end
  end

  always_comb begin
    out_res_o = res_q;
    if (mem_sel_q) begin
      out_res_o.data_word = store_word;
    end
  end

  assign out_valid_o = o_q;

  // The buffer is filled in whole pairs of words.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !wptr_q[0])
    else $error("write pointer is odd");

  // No more words can be pending than the buffer holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   words_q <= CNT_W'(tcrc_pkg::BUFFER_WORDS))
    else $error("words left exceed buffer size");

  // Record data is only parsed under a nonzero header within the length limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   phase_q == tcrc_pkg::PH_DATA |->
                   header_q != '0 && header_q <= 32'(tcrc_pkg::MAX_RECORD_BYTES))
    else $error("data phase with an invalid header length");

  // A stall toward the sender only happens while the input register holds a request.
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_stall_o |-> s1_q && o_q)
    else $error("input stalled with room to advance");

endmodule

// File: test/tape_channel_read_controller_core_test.sv
// Self-checking testbench for the tape channel read controller core with its own prediction.
`timescale 1ns / 100ps

module tape_channel_read_controller_core_test;

  localparam int unsigned RANDOM_REQUESTS = 140;
  localparam int unsigned IDLE_LIMIT      = 2000;
  localparam int unsigned REPORT_LINES    = 20;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  tcrc_pkg::in_req_t     in_req_i    = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  tcrc_pkg::result_t     out_res_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [7:0]            cfg_data_i  = '0;

  tape_channel_read_controller_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_res_o  (out_res_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predicted controller state.
  logic [7:0]        unit_mask;
  logic [11:0]       active_function;
  logic [2:0]        selected_unit;
  logic [5:0]        tape_status;
  int unsigned       words_ready;
  logic [11:0]       record_words [tcrc_pkg::BUFFER_WORDS];
  int unsigned       fetch_index;
  int unsigned       fill_index;
  tcrc_pkg::phase_e  record_phase;
  logic [31:0]       header_len;
  logic [31:0]       trailer_len;
  int unsigned       byte_count;
  logic [15:0]       held_bytes;
  int unsigned       held_count;

  tcrc_pkg::result_t results_due [$];
  tcrc_pkg::result_t want_res;

  int unsigned requests_sent   = 0;
  int unsigned results_checked = 0;
  int unsigned mismatches      = 0;
  int unsigned records_read    = 0;
  int unsigned mask_writes     = 0;
  int unsigned send_gap_max    = 0;
  int unsigned stall_max       = 0;
  int unsigned stall_left      = 0;
  int unsigned idle_cycles     = 0;

  task automatic reset_prediction();
    unit_mask       = 8'h01;
    active_function = '0;
    selected_unit   = '0;
    tape_status     = tcrc_pkg::ST_READY;
    words_ready     = 0;
    fetch_index     = 0;
    fill_index      = 0;
    record_phase    = tcrc_pkg::PH_IDLE;
    header_len      = '0;
    trailer_len     = '0;
    byte_count      = 0;
    held_bytes      = '0;
    held_count      = 0;
    for (int i = 0; i < tcrc_pkg::BUFFER_WORDS; i++) record_words[i] = '0;
  endtask

  task automatic abandon_record(input logic [5:0] st);
    tape_status  = st;
    words_ready  = 0;
    record_phase = tcrc_pkg::PH_IDLE;
  endtask

  task automatic put_record_word(input logic [11:0] w);
    if (fill_index < tcrc_pkg::BUFFER_WORDS) begin
      record_words[fill_index] = w;
      fill_index++;
    end
  endtask

  task automatic pack_byte_group(input logic [7:0] b1, input logic [7:0] b2,
                                 input logic [7:0] b3);
    put_record_word({b1, b2[7:4]});
    put_record_word({b2[3:0], b3});
  endtask

  task automatic tape_controller_step(input tcrc_pkg::in_req_t req,
                                      output tcrc_pkg::result_t res);
    logic [11:0] code;
    logic        attached;
    res = '0;
    case (req.opcode)
      tcrc_pkg::OP_FUNC: begin
        code = req.func_code & tcrc_pkg::FN_MASK;
        res.func_accepted = 1'b1;
        attached = unit_mask[selected_unit];
        case (code)
          tcrc_pkg::FN_WRITE_BIN, tcrc_pkg::FN_BACKSPACE, tcrc_pkg::FN_REWIND_UNLOAD,
          tcrc_pkg::FN_WRITE_BCD, tcrc_pkg::FN_READ_BCD, tcrc_pkg::FN_FILE_MARK: begin
            active_function = '0;
            res.error_code = tcrc_pkg::ER_UNSUPPORTED;
          end
          tcrc_pkg::FN_REWIND: begin
            active_function = '0;
            if (attached) begin
              res.medium_request = tcrc_pkg::MREQ_REWIND;
              res.request_unit = selected_unit;
              record_phase = tcrc_pkg::PH_IDLE;
            end
          end
          tcrc_pkg::FN_STATUS: active_function = req.func_code;
          tcrc_pkg::FN_SELECT: begin
            active_function = '0;
            selected_unit = req.func_code[2:0];
            if (!unit_mask[selected_unit]) res.error_code = tcrc_pkg::ER_SELECT;
          end
          tcrc_pkg::FN_READ_BIN: begin
            active_function = req.func_code;
            tape_status = tcrc_pkg::ST_READY;
            if (words_ready == 0) begin
              fetch_index = 0;
              fill_index  = 0;
              byte_count  = 0;
              header_len  = '0;
              trailer_len = '0;
              held_bytes  = '0;
              held_count  = 0;
              if (!attached) begin
                abandon_record(tcrc_pkg::ST_NOT_READY);
              end else begin
                res.medium_request = tcrc_pkg::MREQ_RECORD;
                res.request_unit = selected_unit;
                record_phase = tcrc_pkg::PH_HEADER;
              end
            end
          end
          default: res.func_accepted = 1'b0;
        endcase
      end
      tcrc_pkg::OP_CHAN_REQ: begin
        code = active_function & tcrc_pkg::FN_MASK;
        if (code == tcrc_pkg::FN_STATUS) begin
          res.data_valid = 1'b1;
          res.data_word = {6'd0, tape_status};
        end else if (code == tcrc_pkg::FN_READ_BIN) begin
          if (!req.channel_full) begin
            if (words_ready == 0) begin
              res.channel_stop = 1'b1;
            end else begin
              words_ready--;
              res.data_valid = 1'b1;
              res.data_word = record_words[fetch_index % tcrc_pkg::BUFFER_WORDS];
              fetch_index = (fetch_index + 1) % tcrc_pkg::BUFFER_WORDS;
            end
          end
        end else begin
          res.error_code = tcrc_pkg::ER_UNSUPPORTED;
        end
      end
      tcrc_pkg::OP_MEDIUM: begin
        case (record_phase)
          tcrc_pkg::PH_HEADER: begin
            header_len = header_len | (32'(req.medium_byte) << (8 * (byte_count % 4)));
            byte_count++;
            if (byte_count == 4) begin
              byte_count = 0;
              if (header_len == 0) begin
                abandon_record(tcrc_pkg::ST_READY);
              end else if (header_len > tcrc_pkg::MAX_RECORD_BYTES) begin
                abandon_record(tcrc_pkg::ST_NOT_READY);
                res.error_code = tcrc_pkg::ER_TOO_LONG;
              end else begin
                record_phase = tcrc_pkg::PH_DATA;
              end
            end
          end
          tcrc_pkg::PH_DATA: begin
            if (held_count == 2) begin
              pack_byte_group(held_bytes[15:8], held_bytes[7:0], req.medium_byte);
              held_bytes = '0;
              held_count = 0;
            end else begin
              held_bytes = {held_bytes[7:0], req.medium_byte};
              held_count++;
            end
            byte_count++;
            if (byte_count >= header_len) begin
              if (held_count == 1) pack_byte_group(held_bytes[7:0], 8'h00, 8'h00);
              else if (held_count == 2)
                pack_byte_group(held_bytes[15:8], held_bytes[7:0], 8'h00);
              held_bytes   = '0;
              held_count   = 0;
              byte_count   = 0;
              trailer_len  = '0;
              record_phase = tcrc_pkg::PH_TRAILER;
            end
          end
          tcrc_pkg::PH_TRAILER: begin
            trailer_len = trailer_len | (32'(req.medium_byte) << (8 * (byte_count % 4)));
            byte_count++;
            if (byte_count == 4) begin
              byte_count = 0;
              if (trailer_len != header_len) begin
                abandon_record(tcrc_pkg::ST_NOT_READY);
                res.error_code = tcrc_pkg::ER_TRAILER;
              end else begin
                words_ready  = fill_index;
                tape_status  = tcrc_pkg::ST_READY;
                record_phase = tcrc_pkg::PH_IDLE;
                records_read++;
              end
            end
          end
          default: ;
        endcase
      end
      default: begin
        case (record_phase)
          tcrc_pkg::PH_HEADER: abandon_record(tcrc_pkg::ST_EOT);
          tcrc_pkg::PH_DATA: begin
            abandon_record(tcrc_pkg::ST_NOT_READY);
            res.error_code = tcrc_pkg::ER_SHORT;
          end
          tcrc_pkg::PH_TRAILER: begin
            abandon_record(tcrc_pkg::ST_NOT_READY);
            res.error_code = tcrc_pkg::ER_TRAILER;
          end
          default: ;
        endcase
      end
    endcase
    res.status_word = tape_status;
  endtask

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= REPORT_LINES)
      $display("Mismatch at result %0d: %s is %0h, expected %0h", results_checked, field,
               got, want);
  endtask

  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      results_checked++;
      if (results_due.size() == 0) begin
        report_mismatch("result without request", 32'(out_res_o), 32'd0);
      end else begin
        want_res = results_due.pop_front();
        if (out_res_o.func_accepted !== want_res.func_accepted)
          report_mismatch("func_accepted", 32'(out_res_o.func_accepted),
                          32'(want_res.func_accepted));
        if (out_res_o.data_valid !== want_res.data_valid)
          report_mismatch("data_valid", 32'(out_res_o.data_valid),
                          32'(want_res.data_valid));
        if (out_res_o.data_word !== want_res.data_word)
          report_mismatch("data_word", 32'(out_res_o.data_word), 32'(want_res.data_word));
        if (out_res_o.channel_stop !== want_res.channel_stop)
          report_mismatch("channel_stop", 32'(out_res_o.channel_stop),
                          32'(want_res.channel_stop));
        if (out_res_o.medium_request !== want_res.medium_request)
          report_mismatch("medium_request", 32'(out_res_o.medium_request),
                          32'(want_res.medium_request));
        if (out_res_o.request_unit !== want_res.request_unit)
          report_mismatch("request_unit", 32'(out_res_o.request_unit),
                          32'(want_res.request_unit));
        if (out_res_o.error_code !== want_res.error_code)
          report_mismatch("error_code", 32'(out_res_o.error_code),
                          32'(want_res.error_code));
        if (out_res_o.status_word !== want_res.status_word)
          report_mismatch("status_word", 32'(out_res_o.status_word),
                          32'(want_res.status_word));
      end
      stall_left = $urandom_range(0, stall_max);
    end else if (stall_left != 0) begin
      stall_left--;
    end
    out_stall_i <= (stall_left != 0);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_request(input tcrc_pkg::in_req_t req);
    int unsigned       gap;
    tcrc_pkg::result_t res;
    gap = $urandom_range(0, send_gap_max);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_req_i   <= req;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    tape_controller_step(req, res);
    results_due.push_back(res);
    requests_sent++;
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_mask(input logic [7:0] mask);
    drain_results();
    cfg_data_i  <= mask;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    unit_mask = mask;
    mask_writes++;
  endtask

  function automatic tcrc_pkg::in_req_t random_fields();
    tcrc_pkg::in_req_t req;
    req.opcode       = 2'($urandom_range(0, 3));
    req.func_code    = 12'($urandom_range(0, 4095));
    req.medium_byte  = 8'($urandom_range(0, 255));
    req.channel_full = 1'($urandom_range(0, 1));
    return req;
  endfunction

  function automatic logic [11:0] known_code();
    case ($urandom_range(0, 9))
      0: return tcrc_pkg::FN_SELECT;
      1: return tcrc_pkg::FN_WRITE_BIN;
      2: return tcrc_pkg::FN_READ_BIN;
      3: return tcrc_pkg::FN_BACKSPACE;
      4: return tcrc_pkg::FN_REWIND;
      5: return tcrc_pkg::FN_REWIND_UNLOAD;
      6: return tcrc_pkg::FN_STATUS;
      7: return tcrc_pkg::FN_WRITE_BCD;
      8: return tcrc_pkg::FN_READ_BCD;
      default: return tcrc_pkg::FN_FILE_MARK;
    endcase
  endfunction

  function automatic tcrc_pkg::in_req_t noise_request();
    tcrc_pkg::in_req_t req;
    req = random_fields();
    if (req.opcode == tcrc_pkg::OP_FUNC && $urandom_range(0, 1) == 1)
      req.func_code = known_code() | 12'($urandom_range(0, 7));
    return req;
  endfunction

  task automatic send_func(input logic [11:0] fc);
    tcrc_pkg::in_req_t req;
    req = random_fields();
    req.opcode = tcrc_pkg::OP_FUNC;
    req.func_code = fc;
    send_request(req);
  endtask

  task automatic send_chan(input logic full);
    tcrc_pkg::in_req_t req;
    req = random_fields();
    req.opcode = tcrc_pkg::OP_CHAN_REQ;
    req.channel_full = full;
    send_request(req);
  endtask

  task automatic send_byte(input logic [7:0] b);
    tcrc_pkg::in_req_t req;
    req = random_fields();
    req.opcode = tcrc_pkg::OP_MEDIUM;
    req.medium_byte = b;
    send_request(req);
  endtask

  task automatic send_medium_end();
    tcrc_pkg::in_req_t req;
    req = random_fields();
    req.opcode = tcrc_pkg::OP_MEDIUM_END;
    send_request(req);
  endtask

  task automatic send_length(input logic [31:0] len);
    for (int i = 0; i < 4; i++) send_byte(len[8*i +: 8]);
  endtask

  task automatic send_data(input int unsigned count);
    repeat (count) send_byte(8'($urandom_range(0, 255)));
  endtask

  // A read binary with words left just reports ready; then the words go out until a stop.
  task automatic read_all_words();
    send_func(tcrc_pkg::FN_READ_BIN | 12'($urandom_range(0, 7)));
    while (words_ready != 0) send_chan($urandom_range(0, 5) == 0);
    send_chan(1'b0);
  endtask

  task automatic test_function_decode();
    send_func(12'o0000);
    send_func(12'o7777);
    send_chan(1'b0);
    send_func(tcrc_pkg::FN_STATUS | 12'o5);
    send_chan(1'b1);
    send_func(tcrc_pkg::FN_WRITE_BIN | 12'o1);
    send_func(tcrc_pkg::FN_BACKSPACE | 12'o2);
    send_func(tcrc_pkg::FN_REWIND_UNLOAD | 12'o3);
    send_func(tcrc_pkg::FN_WRITE_BCD | 12'o4);
    send_func(tcrc_pkg::FN_READ_BCD | 12'o6);
    send_func(tcrc_pkg::FN_FILE_MARK | 12'o7);
    send_func(tcrc_pkg::FN_SELECT | 12'o7);
    send_func(tcrc_pkg::FN_READ_BIN | 12'o7);
    send_chan(1'b0);
    send_chan(1'b1);
    send_func(tcrc_pkg::FN_REWIND);
    send_func(tcrc_pkg::FN_SELECT);
    send_func(tcrc_pkg::FN_REWIND);
  endtask

  task automatic test_record_cases();
    send_func(tcrc_pkg::FN_READ_BIN);
    send_length(32'd0);
    send_func(tcrc_pkg::FN_READ_BIN);
    send_byte(8'hFF);
    send_medium_end();
    send_func(tcrc_pkg::FN_STATUS);
    send_chan(1'b0);
    send_byte(8'h00);
    send_medium_end();
    send_func(tcrc_pkg::FN_READ_BIN);
    send_length(tcrc_pkg::MAX_RECORD_BYTES + 1);
    send_func(tcrc_pkg::FN_READ_BIN);
    send_length(32'hFFFF_FFFF);
    send_func(tcrc_pkg::FN_READ_BIN);
    send_length(32'd5);
    send_data(2);
    send_medium_end();
    send_func(tcrc_pkg::FN_READ_BIN);
    send_length(32'd4);
    send_data(4);
    send_length(32'd5);
    send_func(tcrc_pkg::FN_READ_BIN);
    send_length(32'd2);
    send_data(2);
    send_byte(8'h02);
    send_medium_end();
    send_func(tcrc_pkg::FN_READ_BIN);
    send_length(32'd3);
    send_data(1);
    send_func(tcrc_pkg::FN_REWIND);
    send_byte(8'hA5);
    send_func(tcrc_pkg::FN_READ_BIN);
    send_length(32'd1);
    send_func(tcrc_pkg::FN_STATUS);
    send_chan(1'b1);
    send_data(1);
    send_length(32'd1);
    read_all_words();
    send_func(tcrc_pkg::FN_READ_BIN);
    send_length(32'd2);
    send_data(2);
    send_length(32'd2);
    read_all_words();
  endtask

  task automatic test_unit_mask();
    write_mask(8'h00);
    send_func(tcrc_pkg::FN_SELECT);
    send_func(tcrc_pkg::FN_READ_BIN);
    send_func(tcrc_pkg::FN_REWIND);
    write_mask(8'hFF);
    send_func(tcrc_pkg::FN_SELECT | 12'o7);
    send_func(tcrc_pkg::FN_READ_BIN | 12'o7);
    send_length(32'd3);
    send_data(3);
    send_length(32'd3);
    read_all_words();
    write_mask(8'hA4);
    send_func(tcrc_pkg::FN_SELECT | 12'o5);
    send_func(tcrc_pkg::FN_REWIND);
    send_func(tcrc_pkg::FN_SELECT | 12'o6);
    write_mask(8'h01);
    send_func(tcrc_pkg::FN_SELECT);
  endtask

  // A header at the length limit is taken, and a 64-byte record is read back in full.
  task automatic test_long_record();
    send_func(tcrc_pkg::FN_SELECT);
    read_all_words();
    send_func(tcrc_pkg::FN_READ_BIN);
    send_length(tcrc_pkg::MAX_RECORD_BYTES);
    send_data(5);
    send_medium_end();
    send_func(tcrc_pkg::FN_READ_BIN);
    send_length(32'd64);
    send_data(64);
    send_length(32'd64);
    read_all_words();
  endtask

  task automatic record_exchange();
    logic [2:0]  unit;
    int unsigned len;
    int unsigned reads;
    unit = 3'($urandom_range(0, 7));
    if (unit_mask != 8'h00 && $urandom_range(0, 4) != 0)
      while (!unit_mask[unit]) unit = 3'($urandom_range(0, 7));
    send_func(tcrc_pkg::FN_SELECT | 12'(unit));
    send_func(tcrc_pkg::FN_READ_BIN | 12'($urandom_range(0, 7)));
    len = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 12);
    case ($urandom_range(0, 11))
      0: send_length($urandom | 32'h0000_2000);
      1: begin
        send_data($urandom_range(0, 3));
        send_medium_end();
      end
      2: begin
        send_length(len + 1);
        send_data(len);
        send_medium_end();
      end
      3: begin
        send_length(len);
        send_data(len);
        send_length(len ^ (32'd1 << $urandom_range(0, 31)));
      end
      4: begin
        send_length(len);
        send_data(len);
        send_data($urandom_range(0, 3));
        send_medium_end();
      end
      default: begin
        send_length(len);
        send_data(len);
        send_length(len);
      end
    endcase
    if ($urandom_range(0, 2) == 0) begin
      send_func(tcrc_pkg::FN_STATUS | 12'($urandom_range(0, 7)));
      send_chan(1'($urandom_range(0, 1)));
    end
    send_func(tcrc_pkg::FN_READ_BIN | 12'($urandom_range(0, 7)));
    reads = ($urandom_range(0, 1) == 1) ? words_ready + 1 : $urandom_range(0, words_ready);
    repeat (reads) send_chan($urandom_range(0, 5) == 0);
  endtask

  task automatic test_random_traffic();
    int unsigned stop_at;
    int unsigned exchanges;
    stop_at = requests_sent + RANDOM_REQUESTS;
    exchanges = 0;
    while (requests_sent < stop_at) begin
      if (exchanges % 5 == 0) begin
        send_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 10;
        stall_max    = ($urandom_range(0, 2) == 0) ? 0 : 10;
      end
      if (exchanges % 4 == 3) begin
        case ($urandom_range(0, 7))
          0: write_mask(8'h00);
          1: write_mask(8'hFF);
          default: write_mask(8'($urandom_range(0, 255)));
        endcase
      end
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 4)) send_request(noise_request());
      else record_exchange();
      exchanges++;
    end
  endtask

  initial begin
    reset_prediction();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_function_decode();
    send_gap_max = 10;
    stall_max    = 10;
    test_record_cases();
    send_gap_max = 3;
    stall_max    = 0;
    test_unit_mask();
    test_long_record();
    test_random_traffic();
    drain_results();
    $display("Run covered %0d requests, %0d results, %0d complete records, %0d mask writes.",
             requests_sent, results_checked, records_read, mask_writes);
    if (mismatches == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
